/* design/tte_pkg.sv */
// shared types and constants for the target tracking envelope unit
// no dependencies; every other design file imports this package
package tte_pkg;

   localparam int LEVEL_BITS       = 24;
   localparam int FACTOR_FRAC_BITS = 30;
   localparam int STEP_BITS        = 32;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int SUM_BITS         = STEP_BITS + 1;
   localparam int PROD_BITS        = LEVEL_BITS + STEP_BITS;
   localparam int SHIFT_BITS       = PROD_BITS - FACTOR_FRAC_BITS;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
   // 0.01 in Q1.(LEVEL_BITS-1), rounded
   localparam int REL_THRESH_INT = ((2 ** (LEVEL_BITS - 1)) + 50) / 100;
   localparam logic [LEVEL_BITS-1:0] REL_THRESH = LEVEL_BITS'(REL_THRESH_INT);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE           = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UP_STEP        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOWN_STEP      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_FACTOR = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_FLOOR    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADBAND       = 3'd5;

   localparam logic MODE_LINEAR      = 1'b0;
   localparam logic MODE_EXPONENTIAL = 1'b1;

   localparam logic [STEP_BITS-1:0]  STEP_RESET  = 32'h4000_0000;
   localparam logic [LEVEL_BITS-1:0] FLOOR_RESET = 24'd83886;
   localparam logic [LEVEL_BITS-1:0] BAND_RESET  = 24'd83886;

   typedef struct packed {
      logic                  mode;
      logic [STEP_BITS-1:0]  up_step;
      logic [STEP_BITS-1:0]  down_step;
      logic [STEP_BITS-1:0]  release_factor;
      logic [LEVEL_BITS-1:0] start_floor;
      logic [LEVEL_BITS-1:0] deadband;
   } cfg_type;

endpackage

/* design/tte_req_if.sv */
// input channel: target level and trigger per control tick
// depends on tte_pkg
interface tte_req_if import tte_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] target;
   logic                  trigger;

   modport source (output valid, output target, output trigger, input ready);
   modport sink (input valid, input target, input trigger, output ready);
endinterface

/* design/tte_rsp_if.sv */
// result channel: new envelope level
// depends on tte_pkg
interface tte_rsp_if import tte_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] level;

   modport source (output valid, output level, input ready);
   modport sink (input valid, input level, output ready);
endinterface

/* design/tte_csr_if.sv */
// configuration write channel: register index and write data
// depends on tte_pkg
interface tte_csr_if import tte_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [STEP_BITS-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* design/tte_csr.sv */
// configuration register file for the envelope unit
// depends on tte_pkg and tte_csr_if
module tte_csr import tte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tte_csr_if.sink   csr_chan,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_MODE:           cfg_in.mode           = csr_chan.data[0];
            CSR_UP_STEP:        cfg_in.up_step        = csr_chan.data;
            CSR_DOWN_STEP:      cfg_in.down_step      = csr_chan.data;
            CSR_RELEASE_FACTOR: cfg_in.release_factor = csr_chan.data;
            CSR_START_FLOOR:    cfg_in.start_floor    = csr_chan.data[LEVEL_BITS-1:0];
            CSR_DEADBAND:       cfg_in.deadband       = csr_chan.data[LEVEL_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_LINEAR;
         cfg_ff.up_step        <= STEP_RESET;
         cfg_ff.down_step      <= STEP_RESET;
         cfg_ff.release_factor <= STEP_RESET;
         cfg_ff.start_floor    <= FLOOR_RESET;
         cfg_ff.deadband       <= BAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/tte_core.sv */
// next envelope level from current level, target, trigger and configuration
// depends on tte_pkg; purely combinational, one shared multiplier
module tte_core import tte_pkg::*; (
   input  cfg_type               cfg,
   input  logic [LEVEL_BITS-1:0] level,
   input  logic [LEVEL_BITS-1:0] target,
   input  logic                  trigger,
   output logic [LEVEL_BITS-1:0] next_level
);

   logic                  below;
   logic                  above;
   logic [LEVEL_BITS-1:0] raised;
   logic [SUM_BITS-1:0]   up_sum;
   logic [LEVEL_BITS-1:0] lin_up;
   logic [LEVEL_BITS-1:0] lin_down;
   logic [LEVEL_BITS-1:0] mul_a;
   logic [STEP_BITS-1:0]  factor;
   logic [PROD_BITS-1:0]  prod;
   logic [SHIFT_BITS-1:0] shifted;
   logic [LEVEL_BITS-1:0] scaled;

   // band test is done one bit wider so the ends never wrap
   assign below = ({1'b0, level} + {1'b0, cfg.deadband}) < {1'b0, target};
   assign above = {1'b0, level} > ({1'b0, target} + {1'b0, cfg.deadband});

   assign raised = (level < cfg.start_floor) ? cfg.start_floor : level;

   assign up_sum = SUM_BITS'(level) + SUM_BITS'(cfg.up_step);
   assign lin_up = (up_sum > SUM_BITS'(LEVEL_MAX)) ? LEVEL_MAX : up_sum[LEVEL_BITS-1:0];
   assign lin_down = (STEP_BITS'(level) > cfg.down_step)
                   ? LEVEL_BITS'(STEP_BITS'(level) - cfg.down_step) : '0;

   // release scales the raw level, attack scales the floored level
   assign mul_a  = trigger ? raised : level;
   assign factor = !trigger ? cfg.release_factor
                 : ((raised < target) ? cfg.up_step : cfg.down_step);

   assign prod    = PROD_BITS'(mul_a) * PROD_BITS'(factor);
   assign shifted = prod[PROD_BITS-1:FACTOR_FRAC_BITS];
   assign scaled  = (shifted > SHIFT_BITS'(LEVEL_MAX)) ? LEVEL_MAX
                  : shifted[LEVEL_BITS-1:0];

   always_comb begin
      priority if (trigger && (below || above) && cfg.mode == MODE_LINEAR) begin
         next_level = (level < target) ? lin_up : lin_down;
      end else if (trigger && (below || above)) begin
         next_level = scaled;
      end else if (!trigger && level > REL_THRESH) begin
         next_level = scaled;
      end else begin
         next_level = level;
      end
   end

endmodule

/* design/target_tracking_envelope_unit.sv */
// target tracking envelope unit: input register, combinational level update, output register
// an accepted transfer waits in the input register and moves its level into the output register once that is free
// throughput: one item per cycle while rsp_chan takes each level, limited by the level update loop
// while a finished level waits in the output register the input stage takes one more, then stalls
// reset (synchronous, active high): level 0, pipeline empty, registers to defaults
// depends on tte_pkg, tte_req_if, tte_rsp_if, tte_csr_if, tte_csr, tte_core
module target_tracking_envelope_unit import tte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tte_req_if.sink   req_chan,
   tte_rsp_if.source rsp_chan,
   tte_csr_if.sink   csr_chan
);

   cfg_type               cfg;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [LEVEL_BITS-1:0] s1_target_ff;
   logic                  s1_trigger_ff;
   logic [LEVEL_BITS-1:0] state_ff;
   logic [LEVEL_BITS-1:0] state_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [LEVEL_BITS-1:0] out_level_ff;
   logic                  out_free;
   logic                  s1_fire;
   logic                  req_fire;

   tte_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   tte_core u_core (
      .cfg        (cfg),
      .level      (state_ff),
      .target     (s1_target_ff),
      .trigger    (s1_trigger_ff),
      .next_level (state_in)
   );

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign out_valid_in = s1_fire || (out_valid_ff && !rsp_chan.ready);

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.level = out_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_target_ff  <= req_chan.target;
         s1_trigger_ff <= req_chan.trigger;
      end
      if (s1_fire) begin
         out_level_ff <= state_in;
      end
   end

   // the output register always carries the level just committed to the state
   a_out_matches_state: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> out_level_ff == state_ff)
      else $error("output level differs from envelope state");

   // envelope state only moves when an item leaves the input stage
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(state_ff))
      else $error("envelope state changed without a transfer");

   a_reset_level: assert property (@(posedge clock)
      $past(reset) |-> state_ff == '0)
      else $error("envelope level not cleared by reset");

   // released level at or below threshold holds
   a_release_hold: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !s1_trigger_ff && state_ff <= REL_THRESH |=> $stable(state_ff))
      else $error("release moved a level below threshold");

endmodule

/* verif/envelope_checker.sv */
`timescale 1ns / 1ps
// envelope checker: watches the request, result and register channels, predicts levels
// depends on tte_pkg and the tte_req_if, tte_rsp_if and tte_csr_if interfaces
module envelope_checker import tte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tte_req_if                    req_mon,
   tte_rsp_if                    rsp_mon,
   tte_csr_if                    csr_mon,
   output logic [LEVEL_BITS-1:0] tracked_level,
   output int unsigned           levels_pending,
   output int unsigned           mismatch_count
);

   localparam cfg_type CFG_AT_RESET = '{
      mode:           MODE_LINEAR,
      up_step:        STEP_RESET,
      down_step:      STEP_RESET,
      release_factor: STEP_RESET,
      start_floor:    FLOOR_RESET,
      deadband:       BAND_RESET
   };

   cfg_type               live_cfg;
   logic [LEVEL_BITS-1:0] expected_levels[$];

   // truncating fixed-point multiply, saturated to the level range
   function automatic logic [LEVEL_BITS-1:0] scaled_level(input logic [LEVEL_BITS-1:0] lvl,
                                                          input logic [STEP_BITS-1:0]  factor);
      logic [63:0] prod;
      prod = (64'(lvl) * 64'(factor)) >> FACTOR_FRAC_BITS;
      if (prod > 64'(LEVEL_MAX)) begin
         return LEVEL_MAX;
      end
      return prod[LEVEL_BITS-1:0];
   endfunction

   function automatic logic [LEVEL_BITS-1:0] next_level(input cfg_type               c,
                                                        input logic [LEVEL_BITS-1:0] lvl,
                                                        input logic [LEVEL_BITS-1:0] target,
                                                        input logic                  trigger);
      logic [63:0]           wide;
      logic [LEVEL_BITS-1:0] raised;
      if (trigger) begin
         // band is inclusive on both sides
         if (64'(lvl) + 64'(c.deadband) >= 64'(target) &&
             64'(lvl) <= 64'(target) + 64'(c.deadband)) begin
            return lvl;
         end
         if (c.mode == MODE_LINEAR) begin
            if (lvl < target) begin
               wide = 64'(lvl) + 64'(c.up_step);
               return (wide > 64'(LEVEL_MAX)) ? LEVEL_MAX : wide[LEVEL_BITS-1:0];
            end
            if (64'(lvl) > 64'(c.down_step)) begin
               wide = 64'(lvl) - 64'(c.down_step);
               return wide[LEVEL_BITS-1:0];
            end
            return '0;
         end
         // direction is decided after lifting to the floor
         raised = (lvl < c.start_floor) ? c.start_floor : lvl;
         return scaled_level(raised, (raised < target) ? c.up_step : c.down_step);
      end
      if (lvl > REL_THRESH) begin
         return scaled_level(lvl, c.release_factor);
      end
      return lvl;
   endfunction

   always @(posedge clock) begin
      logic [LEVEL_BITS-1:0] want;
      logic [LEVEL_BITS-1:0] fresh;
      if (reset) begin
         live_cfg       <= CFG_AT_RESET;
         tracked_level  <= '0;
         mismatch_count <= 0;
         levels_pending <= 0;
         expected_levels.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_levels.size() == 0) begin
               $error("level: unexpected transfer, actual %0h", rsp_mon.level);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_mon.level !== want) begin
                  $error("level: expected %0h actual %0h", want, rsp_mon.level);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_MODE:           live_cfg.mode           <= csr_mon.data[0];
               CSR_UP_STEP:        live_cfg.up_step        <= csr_mon.data;
               CSR_DOWN_STEP:      live_cfg.down_step      <= csr_mon.data;
               CSR_RELEASE_FACTOR: live_cfg.release_factor <= csr_mon.data;
               CSR_START_FLOOR:    live_cfg.start_floor    <= csr_mon.data[LEVEL_BITS-1:0];
               CSR_DEADBAND:       live_cfg.deadband       <= csr_mon.data[LEVEL_BITS-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            fresh = next_level(live_cfg, tracked_level, req_mon.target, req_mon.trigger);
            expected_levels.push_back(fresh);
            tracked_level <= fresh;
         end
         levels_pending <= expected_levels.size();
      end
   end

endmodule

/* verif/tb_target_tracking_envelope_unit.sv */
`timescale 1ns / 1ps
// testbench top: clock, reset, directed and random stimulus, register phases, verdict
// depends on tte_pkg, the channel interfaces, envelope_checker and the envelope unit
module tb_target_tracking_envelope_unit;
   import tte_pkg::*;

   localparam int CYCLE_LIMIT     = 800000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_COUNT     = 12;
   localparam int PHASE_ITEMS     = 120;
   localparam int SETTLE_CYCLES   = 4;

   // indexes past the register list, writes there must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic [2:0] {
      PICK_GIVEN,
      PICK_HOLD_ABOVE,
      PICK_MOVE_ABOVE,
      PICK_HOLD_BELOW,
      PICK_MOVE_BELOW,
      PICK_RANDOM
   } target_pick_type;

   logic                  clock;
   logic                  reset;
   logic [LEVEL_BITS-1:0] tracked_level;
   int unsigned           levels_pending;
   int unsigned           mismatch_count;
   int unsigned           cycle_count;
   logic [LEVEL_BITS-1:0] band;
   logic                  quiet;
   logic                  hold_off_req;

   tte_req_if req_chan ();
   tte_rsp_if rsp_chan ();
   tte_csr_if csr_chan ();

   target_tracking_envelope_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   envelope_checker i_envelope_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .tracked_level  (tracked_level),
      .levels_pending (levels_pending),
      .mismatch_count (mismatch_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [LEVEL_BITS-1:0] target_for(input target_pick_type       pick,
                                                        input logic [LEVEL_BITS-1:0] value);
      logic [LEVEL_BITS:0] upper;
      upper = {1'b0, tracked_level} + {1'b0, band};
      case (pick)
         PICK_HOLD_ABOVE: return upper[LEVEL_BITS] ? LEVEL_MAX : upper[LEVEL_BITS-1:0];
         PICK_MOVE_ABOVE: begin
            upper = upper + 1'b1;
            return upper[LEVEL_BITS] ? LEVEL_MAX : upper[LEVEL_BITS-1:0];
         end
         PICK_HOLD_BELOW: return (tracked_level > band) ? tracked_level - band : '0;
         PICK_MOVE_BELOW: return (tracked_level > band) ? tracked_level - band - 1'b1 : '0;
         PICK_RANDOM: begin
            case ($urandom_range(0, 9))
               0: return '0;
               1: return LEVEL_MAX;
               default: return LEVEL_BITS'($urandom());
            endcase
         end
         default: return value;
      endcase
   endfunction

   // the target is chosen after the previous transfer has updated the tracked level
   task automatic send_item(input target_pick_type pick, input logic [LEVEL_BITS-1:0] value,
                            input logic trig);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.target  <= target_for(pick, value);
      req_chan.trigger <= trig;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_random_item();
      target_pick_type pick;
      case ($urandom_range(0, 7))
         0: pick = PICK_HOLD_ABOVE;
         1: pick = PICK_MOVE_ABOVE;
         2: pick = PICK_HOLD_BELOW;
         3: pick = PICK_MOVE_BELOW;
         default: pick = PICK_RANDOM;
      endcase
      send_item(pick, '0, $urandom_range(0, 3) != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [STEP_BITS-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      if (idx == CSR_DEADBAND) begin
         band = data[LEVEL_BITS-1:0];
      end
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // stop offering, drain every level, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      csr_chan.valid <= 1'b0;
      while (levels_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [STEP_BITS-1:0] step_value(input logic expo, input logic growth);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: begin
            if (!expo) begin
               return $urandom_range(0, 32'h0010_0000);
            end else if (growth) begin
               return 32'h4000_0000 + $urandom_range(0, 32'h3FFF_FFFF);
            end
            return 32'h2000_0000 + $urandom_range(0, 32'h1FFF_FFFF);
         end
      endcase
   endfunction

   // upper bits carry junk that the block has to mask
   function automatic logic [STEP_BITS-1:0] level_value(input int unsigned limit);
      logic [STEP_BITS-1:0] v;
      v = $urandom();
      case ($urandom_range(0, 9))
         0: v[LEVEL_BITS-1:0] = '0;
         1: v[LEVEL_BITS-1:0] = LEVEL_MAX;
         default: v[LEVEL_BITS-1:0] = LEVEL_BITS'($urandom_range(0, limit));
      endcase
      return v;
   endfunction

   task automatic load_phase(input int p);
      logic [STEP_BITS-1:0] mode_word;
      logic                 expo;
      if (p == 0) begin
         write_reg(CSR_MODE, '0);
         write_reg(CSR_UP_STEP, '0);
         write_reg(CSR_DOWN_STEP, '0);
         write_reg(CSR_RELEASE_FACTOR, '0);
         write_reg(CSR_START_FLOOR, '0);
         write_reg(CSR_DEADBAND, '0);
      end else if (p == 1) begin
         write_reg(CSR_MODE, '1);
         write_reg(CSR_UP_STEP, '1);
         write_reg(CSR_DOWN_STEP, '1);
         write_reg(CSR_RELEASE_FACTOR, '1);
         write_reg(CSR_START_FLOOR, '1);
         write_reg(CSR_DEADBAND, '1);
      end else begin
         expo         = 1'($urandom_range(0, 1));
         mode_word    = $urandom();
         mode_word[0] = expo;
         write_reg(CSR_MODE, mode_word);
         write_reg(CSR_UP_STEP, step_value(expo, 1'b1));
         write_reg(CSR_DOWN_STEP, step_value(expo, 1'b0));
         write_reg(CSR_RELEASE_FACTOR, step_value(1'b1, 1'b0));
         write_reg(CSR_START_FLOOR, level_value(32'h0010_0000));
         write_reg(CSR_DEADBAND, level_value(32'h0001_0000));
      end
      write_reg(CSR_SPARE_LO, $urandom());
      write_reg(CSR_SPARE_HI, $urandom());
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // a change of hold_off_req starts one long hold-off
   initial begin
      int unsigned stall_left;
      logic        hold_off_seen;
      stall_left     = 0;
      hold_off_seen  = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req != hold_off_seen) begin
            hold_off_seen = hold_off_req;
            stall_left    = HOLD_OFF_CYCLES;
         end
         if (stall_left != 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      reset            = 1'b1;
      band             = BAND_RESET;
      quiet            = 1'b0;
      hold_off_req     = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.target  = '0;
      req_chan.trigger = 1'b0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = CSR_MODE;
      csr_chan.data    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: linear, huge steps, unity release
      send_item(PICK_GIVEN, '0, 1'b0);        // release at zero leaves it alone
      send_item(PICK_GIVEN, LEVEL_MAX, 1'b1); // step up saturates
      send_item(PICK_GIVEN, LEVEL_MAX, 1'b1); // inside the band, holds
      send_item(PICK_GIVEN, '0, 1'b0);        // unity release keeps full scale
      send_item(PICK_GIVEN, '0, 1'b1);        // step down floors at zero

      settle();
      write_reg(CSR_UP_STEP, 32'(REL_THRESH));
      write_reg(CSR_DOWN_STEP, 32'd3000);
      write_reg(CSR_RELEASE_FACTOR, 32'h2000_0000);
      write_reg(CSR_DEADBAND, 32'd50);
      send_item(PICK_GIVEN, LEVEL_MAX, 1'b1); // lands exactly on the release threshold
      send_item(PICK_GIVEN, '0, 1'b0);        // not above threshold, holds
      settle();
      write_reg(CSR_UP_STEP, 32'd1);
      send_item(PICK_GIVEN, LEVEL_MAX, 1'b1);
      send_item(PICK_GIVEN, '0, 1'b0);        // one above threshold, halves
      repeat (2) begin
         send_item(PICK_HOLD_ABOVE, '0, 1'b1);
         send_item(PICK_MOVE_ABOVE, '0, 1'b1);
         send_item(PICK_HOLD_BELOW, '0, 1'b1);
         send_item(PICK_MOVE_BELOW, '0, 1'b1);
      end

      settle();
      write_reg(CSR_MODE, 32'(MODE_EXPONENTIAL));
      write_reg(CSR_UP_STEP, 32'h6000_0000);
      write_reg(CSR_DOWN_STEP, 32'h3000_0000);
      write_reg(CSR_START_FLOOR, 32'h0001_0000);
      send_item(PICK_GIVEN, '0, 1'b1);        // lifted to the floor, then decays
      send_item(PICK_GIVEN, LEVEL_MAX, 1'b1);
      send_item(PICK_GIVEN, LEVEL_MAX, 1'b1);
      send_item(PICK_GIVEN, '0, 1'b0);
      settle();
      write_reg(CSR_UP_STEP, '1);
      send_item(PICK_GIVEN, LEVEL_MAX, 1'b1); // largest up step, scales the level by just under four

      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         load_phase(p);
         quiet = (p % 4 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long result back-pressure while requests keep coming
            if (n == 20 && (p == 3 || p == 8)) begin
               hold_off_req = ~hold_off_req;
            end
            send_random_item();
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
